// ===== src/fmsq_pkg.sv =====
// Package: shared types, fault numbering and constants of the supply fault monitor.
`timescale 1ns / 1ps
package fmsq_pkg;

  // Fault numbering: filters first, then supply and sensor faults
  localparam int FILTER_COUNT = 4;
  localparam int NUM_FAULTS   = FILTER_COUNT + 6;
  localparam int IDX_W        = 4;
  localparam int POS_W        = IDX_W + 1;

  localparam logic [IDX_W-1:0] F_LOST     = IDX_W'(FILTER_COUNT + 0);
  localparam logic [IDX_W-1:0] F_UNSTABLE = IDX_W'(FILTER_COUNT + 1);
  localparam logic [IDX_W-1:0] F_OVERTIME = IDX_W'(FILTER_COUNT + 2);
  localparam logic [IDX_W-1:0] F_TDS_IN   = IDX_W'(FILTER_COUNT + 3);
  localparam logic [IDX_W-1:0] F_TDS_OUT  = IDX_W'(FILTER_COUNT + 4);
  localparam logic [IDX_W-1:0] F_LEAK     = IDX_W'(FILTER_COUNT + 5);

  // Toggles of a short supply pulse before the supply counts as unstable
  localparam logic [7:0] UNSTABLE_TOGGLES = 8'd5;
  localparam logic [7:0] TOGGLE_MAX       = 8'd255;

  // Register reset values
  localparam logic [15:0] RST_TDS_LIMIT     = 16'd65535;
  localparam logic [31:0] RST_HAVE_WATER_MS = 32'd10000;
  localparam logic [31:0] RST_LOST_WATER_MS = 32'd20000;
  localparam logic [31:0] RST_PUMP_OVER_MS  = 32'd18000000;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TDS_LIMIT_INLET  = 3'd0,
    CFG_TDS_LIMIT_OUTLET = 3'd1,
    CFG_HAVE_WATER_MS    = 3'd2,
    CFG_LOST_WATER_MS    = 3'd3,
    CFG_PUMP_OVERTIME_MS = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SUP_NORMAL   = 2'd0,
    SUP_LOST     = 2'd1,
    SUP_UNSTABLE = 2'd2
  } supply_e;

  typedef struct packed {
    logic [15:0] tds_limit_inlet;
    logic [15:0] tds_limit_outlet;
    logic [31:0] have_water_ms;
    logic [31:0] lost_water_ms;
    logic [31:0] pump_overtime_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0]             now_ms;
    logic [FILTER_COUNT-1:0] filter_expired;
    logic                    water_present;
    logic [31:0]             pump_run_ms;
    logic [15:0]             tds_inlet;
    logic [15:0]             tds_outlet;
    logic                    leak_detected;
    logic [IDX_W-1:0]        query_index;
  } poll_t;

  typedef struct packed {
    logic [NUM_FAULTS-1:0] fault_flags;
    logic [NUM_FAULTS-1:0] new_faults;
    logic [IDX_W-1:0]      last_new_fault;
    logic                  all_cleared;
    logic                  cancel_display;
    logic                  pump_off;
    logic [IDX_W-1:0]      next_fault;
    logic                  next_valid;
  } result_t;

  typedef struct packed {
    logic [NUM_FAULTS-1:0] fault_latch;
    supply_e               supply_state;
    logic                  water_seen_before;
    logic [31:0]           time_water_arrived;
    logic [31:0]           time_water_left;
    logic [7:0]            toggle_count;
    logic [IDX_W-1:0]      recent_fault;
    logic                  any_fault_before;
  } state_t;

endpackage

// ===== src/fmsq_if.sv =====
// Interfaces: poll channel, result channel and register write channel.
`timescale 1ns / 1ps

interface fmsq_poll_if import fmsq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [31:0]             now_ms;
  logic [FILTER_COUNT-1:0] filter_expired;
  logic                    water_present;
  logic [31:0]             pump_run_ms;
  logic [15:0]             tds_inlet;
  logic [15:0]             tds_outlet;
  logic                    leak_detected;
  logic [IDX_W-1:0]        query_index;

  modport source (output valid, now_ms, filter_expired, water_present, pump_run_ms,
                  tds_inlet, tds_outlet, leak_detected, query_index, input ready);
  modport sink (input valid, now_ms, filter_expired, water_present, pump_run_ms,
                tds_inlet, tds_outlet, leak_detected, query_index, output ready);
endinterface

interface fmsq_result_if import fmsq_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [NUM_FAULTS-1:0] fault_flags;
  logic [NUM_FAULTS-1:0] new_faults;
  logic [IDX_W-1:0]      last_new_fault;
  logic                  all_cleared;
  logic                  cancel_display;
  logic                  pump_off;
  logic [IDX_W-1:0]      next_fault;
  logic                  next_valid;

  modport source (output valid, fault_flags, new_faults, last_new_fault, all_cleared,
                  cancel_display, pump_off, next_fault, next_valid, input ready);
  modport sink (input valid, fault_flags, new_faults, last_new_fault, all_cleared,
                cancel_display, pump_off, next_fault, next_valid, output ready);
endinterface

interface fmsq_cfg_if import fmsq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/fault_monitor_supply_qualifier.sv =====
// Top level: poll register, state registers, result register and channel handshakes.
//
// Fault monitor with supply qualifier. Each poll word on poll_i gives exactly one result
// word on result_o. A poll is taken every clock cycle while results drain: the sustained
// rate is one poll per cycle. Each poll is held first in the poll register, then in the
// result register. The rate is set by the single-pass update logic, whose state
// (latched faults, supply qualifier, timestamps, toggle counter) closes its loop through
// the state register alone. A stalled result_o holds the result and the poll register,
// and poll_i.ready drops only when both are full. The user must write thresholds on cfg_i
// (always ready) only while no poll is in flight; the block itself does not enforce it.
// Indexes beyond the register list are ignored. Timestamp differences wrap modulo 2^32.
`timescale 1ns / 1ps
module fault_monitor_supply_qualifier import fmsq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  fmsq_poll_if.sink   poll_i,
  fmsq_result_if.source result_o,
  fmsq_cfg_if.sink    cfg_i
);

  cfg_t    cfg;
  poll_t   poll_q;
  logic    poll_vld_q;
  state_t  state_q, state_d;
  result_t res_q, res_d;
  logic    res_vld_q;
  logic    advance;
  logic    fire;
  logic    take;

  // Registers
  fmsq_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_i.valid && cfg_i.ready),
    .wr_index_i (cfg_reg_e'(cfg_i.index)),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );
  assign cfg_i.ready = 1'b1;

  // Pipeline handshake
  assign advance      = !res_vld_q || result_o.ready;
  assign fire         = poll_vld_q && advance;
  assign poll_i.ready = !poll_vld_q || advance;
  assign take         = poll_i.valid && poll_i.ready;

  // Poll register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_vld_q <= 1'b0;
    end else if (poll_i.ready) begin
      poll_vld_q <= poll_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      poll_q.now_ms         <= poll_i.now_ms;
      poll_q.filter_expired <= poll_i.filter_expired;
      poll_q.water_present  <= poll_i.water_present;
      poll_q.pump_run_ms    <= poll_i.pump_run_ms;
      poll_q.tds_inlet      <= poll_i.tds_inlet;
      poll_q.tds_outlet     <= poll_i.tds_outlet;
      poll_q.leak_detected  <= poll_i.leak_detected;
      poll_q.query_index    <= poll_i.query_index;
    end
  end

  // Update logic
  fmsq_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .poll_i   (poll_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Monitor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.fault_latch        <= '0;
      state_q.supply_state       <= SUP_NORMAL;
      state_q.water_seen_before  <= 1'b1;
      state_q.time_water_arrived <= '0;
      state_q.time_water_left    <= '0;
      state_q.toggle_count       <= '0;
      state_q.recent_fault       <= '0;
      state_q.any_fault_before   <= 1'b0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= poll_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid          = res_vld_q;
  assign result_o.fault_flags    = res_q.fault_flags;
  assign result_o.new_faults     = res_q.new_faults;
  assign result_o.last_new_fault = res_q.last_new_fault;
  assign result_o.all_cleared    = res_q.all_cleared;
  assign result_o.cancel_display = res_q.cancel_display;
  assign result_o.pump_off       = res_q.pump_off;
  assign result_o.next_fault     = res_q.next_fault;
  assign result_o.next_valid     = res_q.next_valid;

endmodule

// ===== src/fmsq_cfg_regs.sv =====
// Configuration register file: thresholds and supply timings.
`timescale 1ns / 1ps
module fmsq_cfg_regs import fmsq_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_en_i,
  input  cfg_reg_e       wr_index_i,
  input  logic [31:0]    wr_data_i,
  output cfg_t           cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode a write; indexes beyond the list are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        CFG_TDS_LIMIT_INLET:  cfg_d.tds_limit_inlet  = wr_data_i[15:0];
        CFG_TDS_LIMIT_OUTLET: cfg_d.tds_limit_outlet = wr_data_i[15:0];
        CFG_HAVE_WATER_MS:    cfg_d.have_water_ms    = wr_data_i;
        CFG_LOST_WATER_MS:    cfg_d.lost_water_ms    = wr_data_i;
        CFG_PUMP_OVERTIME_MS: cfg_d.pump_overtime_ms = wr_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tds_limit_inlet  <= RST_TDS_LIMIT;
      cfg_q.tds_limit_outlet <= RST_TDS_LIMIT;
      cfg_q.have_water_ms    <= RST_HAVE_WATER_MS;
      cfg_q.lost_water_ms    <= RST_LOST_WATER_MS;
      cfg_q.pump_overtime_ms <= RST_PUMP_OVER_MS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/fmsq_step.sv =====
// Single-poll update: fault latching, supply qualifier and next-fault search.
`timescale 1ns / 1ps
module fmsq_step import fmsq_pkg::*; (
  input  cfg_t    cfg_i,
  input  state_t  state_i,
  input  poll_t   poll_i,
  output state_t  state_o,
  output result_t result_o
);

  logic [NUM_FAULTS-1:0] latch;
  logic [NUM_FAULTS-1:0] raised;
  logic [IDX_W-1:0]      recent;
  supply_e               sup;
  logic                  seen;
  logic [31:0]           arrived;
  logic [31:0]           left_at;
  logic [7:0]            toggles;
  logic [7:0]            toggles_inc;
  logic                  cancel;
  logic                  pump_off;
  logic [31:0]           since_arrived;
  logic [31:0]           since_left;
  logic [IDX_W-1:0]      start;
  logic [POS_W-1:0]      pos;
  logic [IDX_W-1:0]      next;
  logic                  next_vld;

  assign since_arrived = poll_i.now_ms - state_i.time_water_arrived;
  assign toggles_inc   = (state_i.toggle_count == TOGGLE_MAX) ? TOGGLE_MAX
                                                              : state_i.toggle_count + 8'd1;

  always_comb begin
    latch    = state_i.fault_latch;
    raised   = '0;
    recent   = state_i.recent_fault;
    sup      = state_i.supply_state;
    seen     = state_i.water_seen_before;
    arrived  = state_i.time_water_arrived;
    left_at  = state_i.time_water_left;
    toggles  = state_i.toggle_count;
    cancel   = 1'b0;
    pump_off = 1'b0;

    // Filter faults follow the expiry bits; raised in index order
    for (int i = 0; i < FILTER_COUNT; i++) begin
      if (poll_i.filter_expired[i]) begin
        if (!latch[i]) begin
          latch[i]  = 1'b1;
          raised[i] = 1'b1;
          recent    = IDX_W'(i);
        end
      end else begin
        latch[i] = 1'b0;
      end
    end

    // Supply qualifier
    if (poll_i.water_present) begin
      if (!seen) begin
        seen    = 1'b1;
        arrived = poll_i.now_ms;
      end else if (since_arrived > cfg_i.have_water_ms) begin
        toggles = 8'd0;
        if (sup != SUP_NORMAL) begin
          sup              = SUP_NORMAL;
          latch[F_LOST]     = 1'b0;
          latch[F_UNSTABLE] = 1'b0;
        end
      end
      if (sup == SUP_LOST) begin
        sup           = SUP_NORMAL;
        latch[F_LOST] = 1'b0;
        cancel        = (recent == F_LOST);
      end
    end else if (seen) begin
      seen    = 1'b0;
      left_at = poll_i.now_ms;
      if (since_arrived < cfg_i.have_water_ms) begin
        toggles = toggles_inc;
        if (toggles_inc >= UNSTABLE_TOGGLES && sup != SUP_UNSTABLE) begin
          sup                = SUP_UNSTABLE;
          latch[F_LOST]      = 1'b0;
          latch[F_UNSTABLE]  = 1'b1;
          raised[F_UNSTABLE] = 1'b1;
          recent             = F_UNSTABLE;
          toggles            = 8'd0;
        end
      end
    end

    // Long absence: supply lost
    since_left = poll_i.now_ms - left_at;
    if (!poll_i.water_present && !seen && since_left > cfg_i.lost_water_ms &&
        sup != SUP_LOST) begin
      sup               = SUP_LOST;
      latch[F_UNSTABLE] = 1'b0;
      latch[F_LOST]     = 1'b1;
      raised[F_LOST]    = 1'b1;
      recent            = F_LOST;
    end

    // Pump, TDS and leak faults stay latched until reset
    if (poll_i.pump_run_ms > cfg_i.pump_overtime_ms && !latch[F_OVERTIME]) begin
      latch[F_OVERTIME]  = 1'b1;
      raised[F_OVERTIME] = 1'b1;
      recent             = F_OVERTIME;
    end
    if (poll_i.tds_inlet > cfg_i.tds_limit_inlet && !latch[F_TDS_IN]) begin
      latch[F_TDS_IN]  = 1'b1;
      raised[F_TDS_IN] = 1'b1;
      recent           = F_TDS_IN;
    end
    if (poll_i.tds_outlet > cfg_i.tds_limit_outlet && !latch[F_TDS_OUT]) begin
      latch[F_TDS_OUT]  = 1'b1;
      raised[F_TDS_OUT] = 1'b1;
      recent            = F_TDS_OUT;
    end
    if (poll_i.leak_detected && !latch[F_LEAK]) begin
      latch[F_LEAK]  = 1'b1;
      raised[F_LEAK] = 1'b1;
      recent         = F_LEAK;
      pump_off       = 1'b1;
    end
  end

  // Circular search after the query index; nearest offset wins
  always_comb begin
    start    = (poll_i.query_index < IDX_W'(NUM_FAULTS)) ? poll_i.query_index
                                                         : IDX_W'(NUM_FAULTS - 1);
    next     = '0;
    next_vld = 1'b0;
    pos      = '0;
    for (int k = NUM_FAULTS; k >= 1; k--) begin
      pos = {1'b0, start} + POS_W'(k);
      if (pos >= POS_W'(NUM_FAULTS)) begin
        pos = pos - POS_W'(NUM_FAULTS);
      end
      if (latch[pos[IDX_W-1:0]]) begin
        next     = pos[IDX_W-1:0];
        next_vld = 1'b1;
      end
    end
  end

  // Next state
  always_comb begin
    state_o.fault_latch        = latch;
    state_o.supply_state       = sup;
    state_o.water_seen_before  = seen;
    state_o.time_water_arrived = arrived;
    state_o.time_water_left    = left_at;
    state_o.toggle_count       = toggles;
    state_o.recent_fault       = recent;
    state_o.any_fault_before   = |latch;
  end

  // Result word
  always_comb begin
    result_o.fault_flags    = latch;
    result_o.new_faults     = raised;
    result_o.last_new_fault = recent;
    result_o.all_cleared    = state_i.any_fault_before && (latch == '0);
    result_o.cancel_display = cancel;
    result_o.pump_off       = pump_off;
    result_o.next_fault     = next;
    result_o.next_valid     = next_vld;
  end

endmodule
